// ===== rtl/hpq_pkg.sv =====
// ----------------------------------------------------------------------------
// hpq_pkg
// Shared types, constants and helpers for the binary heap priority queue.
// ----------------------------------------------------------------------------
package hpq_pkg;

    localparam int DEPTH  = 128;
    localparam int DATA_W = 32;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = 8;

    localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(100);
    localparam logic [CNT_W-1:0] CAP_MAX   = CNT_W'(DEPTH);

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_POP    = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        STAT_DONE  = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2
    } t_status;

    typedef enum logic {
        REG_HEAP_MODE = 1'b0,
        REG_CAPACITY  = 1'b1
    } t_reg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UP_CMP,
        S_PUT,
        S_POP_CMP,
        S_DOWN_CMP
    } t_state;

    // a must sit above b: mode 0 smallest on top, mode 1 largest on top
    function automatic logic beats(input logic mode,
                                   input logic [DATA_W-1:0] a,
                                   input logic [DATA_W-1:0] b);
        return mode ? ($signed(a) > $signed(b)) : ($signed(a) < $signed(b));
    endfunction

    function automatic logic [ADDR_W-1:0] parent_of(input logic [ADDR_W-1:0] pos);
        logic [ADDR_W-1:0] dec;
        dec = pos - ADDR_W'(1);
        return dec >> 1;
    endfunction

endpackage

// ===== rtl/binary_heap_priority_queue_unit.sv =====
// ----------------------------------------------------------------------------
// binary_heap_priority_queue_unit
// Min or max binary heap of signed words held in one two-read RAM.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: raise i_start with i_op/i_value while o_busy is low; the
//   word is taken at that clock edge. Insert puts i_value into the heap, pop
//   removes the top word. Exactly one result word follows, shown for one
//   cycle with o_done high: o_status, o_top_value, o_fill_count.
//   Full/empty and insert into an empty heap finish straight from idle.
//   Insert climbs in S_UP_CMP, writing at the root in S_PUT if it gets
//   there; pop reads the root and last word, then walks down in S_DOWN_CMP.
//   Each tree level costs one RAM read, compare and write back; the read of
//   the next level is issued in the same cycle, so one level per cycle.
//   o_busy is low in the strobe cycle, so a new command can follow at once.
//   Config port: i_cfg_we writes i_cfg_data to register i_cfg_index (0 heap
//   mode, 1 capacity) and empties the heap; write only while idle.
//   Reset (synchronous, active low) empties the heap, selects min ordering
//   and a capacity of 100. The receiver cannot stall; o_done is not held.
// ----------------------------------------------------------------------------
module binary_heap_priority_queue_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    output logic                        o_busy,
    input  logic                        i_op,
    input  logic [hpq_pkg::DATA_W-1:0]  i_value,
    output logic                        o_done,
    output logic [1:0]                  o_status,
    output logic [hpq_pkg::DATA_W-1:0]  o_top_value,
    output logic [hpq_pkg::CNT_W-1:0]   o_fill_count,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_index,
    input  logic [hpq_pkg::CNT_W-1:0]   i_cfg_data
);
    import hpq_pkg::*;

    // heap storage
    logic [DATA_W-1:0] mem [DEPTH];
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [DATA_W-1:0] mem_wdata;
    logic [ADDR_W-1:0] addr_a;
    logic [ADDR_W-1:0] addr_b;
    logic [DATA_W-1:0] rd_a;
    logic [DATA_W-1:0] rd_b;

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              r_mode;
    logic [CNT_W-1:0]  r_cap;
    logic              r_done, n_done;
    logic [ADDR_W-1:0] r_pos, n_pos;
    logic [DATA_W-1:0] r_cur, n_cur;
    t_status           r_status, n_status;
    logic [DATA_W-1:0] r_top, n_top;

    logic [CNT_W-1:0]  lim;
    logic [ADDR_W-1:0] par;
    logic [CNT_W-1:0]  l_idx;
    logic [CNT_W:0]    r_idx;
    logic              take_l;
    logic              take_r;
    logic [DATA_W-1:0] l_win;
    logic [CNT_W-1:0]  nl_idx;
    logic [CNT_W:0]    nr_idx;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_a <= mem[addr_a];
        rd_b <= mem[addr_b];
    end

    assign lim   = (r_cap > CAP_MAX) ? CAP_MAX : r_cap;
    assign par   = parent_of(r_pos);
    assign l_idx = {1'b0, r_pos} * CNT_W'(2) + CNT_W'(1);
    assign r_idx = {1'b0, l_idx} + (CNT_W+1)'(1);

    // down step: left wins only over the moving word, right over the winner so far
    assign take_l = (l_idx < r_count) && beats(r_mode, rd_a, r_cur);
    assign l_win  = take_l ? rd_a : r_cur;
    assign take_r = (r_idx < {1'b0, r_count}) && beats(r_mode, rd_b, l_win);

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_done    = 1'b0;
        n_pos     = r_pos;
        n_cur     = r_cur;
        n_status  = r_status;
        n_top     = r_top;
        mem_we    = 1'b0;
        mem_waddr = r_pos;
        mem_wdata = r_cur;
        addr_a    = parent_of(r_count[ADDR_W-1:0]);
        addr_b    = ADDR_W'(r_count - CNT_W'(1));
        nl_idx    = '0;
        nr_idx    = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_top = '0;
                    if (i_op == OP_INSERT) begin
                        if (r_count >= lim) begin
                            n_status = STAT_FULL;
                            n_done   = 1'b1;
                        end else begin
                            n_status = STAT_DONE;
                            n_count  = r_count + CNT_W'(1);
                            n_cur    = i_value;
                            n_pos    = r_count[ADDR_W-1:0];
                            if (r_count == '0) begin
                                mem_we    = 1'b1;
                                mem_waddr = '0;
                                mem_wdata = i_value;
                                n_done    = 1'b1;
                            end else begin
                                // parent read already issued on port A
                                n_state = S_UP_CMP;
                            end
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_status = STAT_EMPTY;
                            n_done   = 1'b1;
                        end else begin
                            n_status = STAT_DONE;
                            n_count  = r_count - CNT_W'(1);
                            addr_a   = '0;
                            n_state  = S_POP_CMP;
                        end
                    end
                end
            end
            S_UP_CMP: begin
                if (beats(r_mode, r_cur, rd_a)) begin
                    // parent moves down into the hole
                    mem_we    = 1'b1;
                    mem_waddr = r_pos;
                    mem_wdata = rd_a;
                    n_pos     = par;
                    addr_a    = parent_of(par);
                    if (par == '0) begin
                        n_state = S_PUT;
                    end
                end else begin
                    mem_we    = 1'b1;
                    mem_waddr = r_pos;
                    mem_wdata = r_cur;
                    n_done    = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            S_PUT: begin
                mem_we    = 1'b1;
                mem_waddr = r_pos;
                mem_wdata = r_cur;
                n_done    = 1'b1;
                n_state   = S_IDLE;
            end
            S_POP_CMP: begin
                n_top = rd_a;
                if (r_count == '0) begin
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    // last word enters at the root; fetch both children
                    n_cur   = rd_b;
                    n_pos   = '0;
                    addr_a  = ADDR_W'(1);
                    addr_b  = ADDR_W'(2);
                    n_state = S_DOWN_CMP;
                end
            end
            S_DOWN_CMP: begin
                mem_we    = 1'b1;
                mem_waddr = r_pos;
                if (take_r) begin
                    mem_wdata = rd_b;
                    n_pos     = r_idx[ADDR_W-1:0];
                end else if (take_l) begin
                    mem_wdata = rd_a;
                    n_pos     = l_idx[ADDR_W-1:0];
                end else begin
                    mem_wdata = r_cur;
                    n_done    = 1'b1;
                    n_state   = S_IDLE;
                end
                nl_idx = {1'b0, n_pos} * CNT_W'(2) + CNT_W'(1);
                nr_idx = {1'b0, nl_idx} + (CNT_W+1)'(1);
                addr_a = nl_idx[ADDR_W-1:0];
                addr_b = nr_idx[ADDR_W-1:0];
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (i_cfg_we) begin
            n_count = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_mode  <= 1'b0;
            r_cap   <= CAP_RESET;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_done  <= n_done;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_HEAP_MODE: r_mode <= i_cfg_data[0];
                    REG_CAPACITY:  r_cap  <= i_cfg_data;
                    default:       r_cap  <= r_cap;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos    <= n_pos;
        r_cur    <= n_cur;
        r_status <= n_status;
        r_top    <= n_top;
    end

    assign o_busy       = (r_state != S_IDLE);
    assign o_done       = r_done;
    assign o_status     = r_status;
    assign o_top_value  = r_top;
    assign o_fill_count = r_count;

endmodule
